FILE: design/tcw_pkg.sv
// Shared types, constants and helper functions of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int DEFAULT_SCREEN_COLS = 80;
   localparam int DEFAULT_SCREEN_ROWS = 25;

   localparam int REQ_TYPE_W  = 2;
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int READ_ROW_W  = 5;
   localparam int READ_COL_W  = 7;
   localparam int POSITION_W  = 11;
   localparam int CELL_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_FG = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_BG = 2'd1;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   localparam logic [COLOR_W-1:0] RESET_FILL_FG = 4'hF;
   localparam logic [COLOR_W-1:0] RESET_FILL_BG = 4'h1;

   function automatic logic [CELL_W-1:0] cell_pack(input logic [CHAR_W-1:0] ch,
                                                   input logic [COLOR_W-1:0] fg,
                                                   input logic [COLOR_W-1:0] bg);
      return {bg, fg, ch};
   endfunction

endpackage

FILE: design/tcw_if.sv
// Request, response and register write channels of the text console writer.
`timescale 1ns / 1ps

interface tcw_req_if;
   import tcw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CHAR_W-1:0]     char_code;
   logic [COLOR_W-1:0]    fore_color;
   logic [COLOR_W-1:0]    back_color;
   logic [READ_ROW_W-1:0] read_row;
   logic [READ_COL_W-1:0] read_col;
   modport source (output valid, req_type, char_code, fore_color, back_color, read_row,
                   read_col, input ready);
   modport sink (input valid, req_type, char_code, fore_color, back_color, read_row,
                 read_col, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [POSITION_W-1:0] cursor_position;
   logic [CELL_W-1:0]     cell_value;
   modport source (output valid, cursor_position, cell_value, input ready);
   modport sink (input valid, cursor_position, cell_value, output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/text_console_writer_unit.sv
// Text console writer: a cell-array text screen with a cursor, held in one RAM.
//
// Each accepted request is executed from a latched copy while the previous response may
// still wait in the output register. All cell traffic goes through the single write port
// and single registered read port of the cell RAM, so bulk operations sweep the cells one
// address at a time: a clear writes every cell, and a character that scrolls the screen
// moves every row up by one row and then fills the bottom row. Cells are undefined until
// written; reading one first is not allowed. The user must write the scroll fill colors
// through the register port only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLS = DEFAULT_SCREEN_COLS,
   parameter int SCREEN_ROWS = DEFAULT_SCREEN_ROWS
) (
   input logic     clock,
   input logic     reset,
   tcw_req_if.sink   req_bus,
   tcw_rsp_if.source rsp_bus,
   tcw_csr_if.sink   csr_bus
);

   localparam int Cells = SCREEN_COLS * SCREEN_ROWS;
   localparam int AddrW = $clog2(Cells);
   localparam int ColW  = $clog2(SCREEN_COLS);
   localparam int RowW  = $clog2(SCREEN_ROWS);
   localparam logic [AddrW-1:0] LastMove = AddrW'(Cells - SCREEN_COLS);
   localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_FILL,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   req_kind_type          req_kind_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic [COLOR_W-1:0]    fg_ff;
   logic [COLOR_W-1:0]    bg_ff;
   logic [READ_ROW_W-1:0] read_row_ff;
   logic [READ_COL_W-1:0] read_col_ff;
   logic [ColW-1:0]       col_ff;
   logic [RowW-1:0]       row_ff;
   logic [AddrW-1:0]      sweep_ff;
   logic [CELL_W-1:0]     cell_ff;
   logic [COLOR_W-1:0]    fill_fg_ff;
   logic [COLOR_W-1:0]    fill_bg_ff;
   logic                  rsp_valid_ff;
   logic [POSITION_W-1:0] rsp_pos_ff;
   logic [CELL_W-1:0]     rsp_cell_ff;

   logic [ColW:0]             col_in;
   logic [RowW:0]             row_in;
   logic                      scroll_needed;
   logic [POSITION_W-1:0]     pos_in;
   logic [POSITION_W-1:0]     pos_now;
   logic [POSITION_W+AddrW-1:0] pos_in_wide;
   logic [POSITION_W+AddrW-1:0] pos_now_wide;
   logic                      put_we;
   logic [AddrW-1:0]          put_addr;
   logic [CELL_W-1:0]         put_data;
   logic                      read_in_range;
   logic [AddrW-1:0]          read_addr;
   logic                      out_free;
   logic                      rsp_load;

   logic                 ram_we;
   logic [AddrW-1:0]     ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic [AddrW-1:0]     ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(Cells)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load      = out_free && ((state_ff == ST_FINISH) ||
                          ((state_ff == ST_EXEC) && (req_kind_ff == REQ_PUT) && !scroll_needed));
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.cursor_position = rsp_pos_ff;
   assign rsp_bus.cell_value      = rsp_cell_ff;

   always_comb begin
      col_in   = {1'b0, col_ff};
      row_in   = {1'b0, row_ff};
      put_we   = 1'b0;
      put_addr = AddrW'(int'(row_ff) * SCREEN_COLS + int'(col_ff));
      put_data = cell_pack(char_ff, fg_ff, bg_ff);
      if (char_ff == CHAR_NEWLINE) begin
         col_in = '0;
         row_in = row_in + 1'b1;
      end else if (char_ff == CHAR_BACKSPACE) begin
         if (col_ff != '0) begin
            col_in   = col_in - 1'b1;
            put_we   = 1'b1;
            put_addr = AddrW'(int'(row_ff) * SCREEN_COLS + int'(col_ff) - 1);
            put_data = cell_pack(CHAR_SPACE, fg_ff, bg_ff);
         end
      end else begin
         put_we = 1'b1;
         col_in = col_in + 1'b1;
      end
      if (int'(col_in) >= SCREEN_COLS) begin
         col_in = '0;
         row_in = row_in + 1'b1;
      end
      scroll_needed = int'(row_in) >= SCREEN_ROWS;
      pos_in_wide   = (POSITION_W + AddrW)'(int'(row_in[RowW-1:0]) * SCREEN_COLS
                                           + int'(col_in[ColW-1:0]));
      pos_in        = pos_in_wide[POSITION_W-1:0];
      pos_now_wide  = (POSITION_W + AddrW)'(int'(row_ff) * SCREEN_COLS + int'(col_ff));
      pos_now       = pos_now_wide[POSITION_W-1:0];
      read_in_range = (int'(read_row_ff) < SCREEN_ROWS) && (int'(read_col_ff) < SCREEN_COLS);
      read_addr     = AddrW'(int'(read_row_ff) * SCREEN_COLS + int'(read_col_ff));
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = sweep_ff;
      ram_wdata = ram_rdata;
      ram_raddr = read_addr;
      unique case (state_ff)
         ST_EXEC: begin
            ram_we    = put_we && (req_kind_ff == REQ_PUT);
            ram_waddr = put_addr;
            ram_wdata = put_data;
         end
         ST_SCROLL: begin
            ram_raddr = AddrW'(int'(sweep_ff) + SCREEN_COLS);
            ram_we    = (sweep_ff != '0);
            ram_waddr = sweep_ff - 1'b1;
            ram_wdata = ram_rdata;
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = cell_pack(CHAR_SPACE, fill_fg_ff, fill_bg_ff);
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = cell_pack(CHAR_SPACE, fg_ff, bg_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_fg_ff <= RESET_FILL_FG;
         fill_bg_ff <= RESET_FILL_BG;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_FILL_FG) begin
            fill_fg_ff <= csr_bus.data;
         end else if (csr_bus.index == CSR_FILL_BG) begin
            fill_bg_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  req_kind_ff <= req_kind_type'(req_bus.req_type);
                  char_ff     <= req_bus.char_code;
                  fg_ff       <= req_bus.fore_color;
                  bg_ff       <= req_bus.back_color;
                  read_row_ff <= req_bus.read_row;
                  read_col_ff <= req_bus.read_col;
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               cell_ff  <= '0;
               sweep_ff <= '0;
               unique case (req_kind_ff)
                  REQ_PUT: begin
                     if (scroll_needed) begin
                        state_ff <= ST_SCROLL;
                     end else begin
                        col_ff <= col_in[ColW-1:0];
                        row_ff <= row_in[RowW-1:0];
                        if (out_free) begin
                           rsp_pos_ff   <= pos_in;
                           rsp_cell_ff  <= '0;
                           state_ff     <= ST_IDLE;
                        end else begin
                           state_ff <= ST_FINISH;
                        end
                     end
                  end
                  REQ_CLEAR: begin
                     state_ff <= ST_CLEAR;
                  end
                  REQ_READ: begin
                     state_ff <= read_in_range ? ST_READ : ST_FINISH;
                  end
                  REQ_NONE: begin
                     state_ff <= ST_FINISH;
                  end
               endcase
            end
            ST_READ: begin
               cell_ff  <= ram_rdata;
               state_ff <= ST_FINISH;
            end
            ST_SCROLL: begin
               if (sweep_ff == LastMove) begin
                  state_ff <= ST_FILL;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            ST_FILL: begin
               if (sweep_ff == LastCell) begin
                  row_ff   <= RowW'(SCREEN_ROWS - 1);
                  col_ff   <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            ST_CLEAR: begin
               if (sweep_ff == LastCell) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_pos_ff   <= pos_now;
                  rsp_cell_ff  <= cell_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) < SCREEN_ROWS) && (int'(col_ff) < SCREEN_COLS))
      else $error("Cursor left the screen.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("Cell RAM written while idle.");

   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_EXEC))
      else $error("Accepted transaction was not executed.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (int'(ram_waddr) >= Cells - SCREEN_COLS))
      else $error("Scroll fill wrote outside the bottom row.");

endmodule

FILE: design/tcw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
